@@ design/hrle_pkg.sv @@
// Shared types, constants and a helper function of the hex record line encoder.
package hrle_pkg;

  localparam int LINE_BYTES = 8;
  localparam int CNT_W      = $clog2(LINE_BYTES + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOAD_OFFSET = 2'd0,
    REG_PAD_BYTE    = 2'd1,
    REG_LINE_TERM   = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] TERM_RESET = 8'd31;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2E;

  // One classified command, passed from the front end to the back end.
  typedef struct packed {
    logic             is_end;
    logic             opens;
    logic             closes;
    logic [7:0]       data;
    logic [15:0]      addr;
    logic [CNT_W-1:0] npad;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_char = 8'h30 + wide;
    end else begin
      hex_char = 8'h37 + wide;
    end
  endfunction

endpackage

@@ design/hrle_fifo.sv @@
// Short command queue between the front end and the back end.
module hrle_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  hrle_pkg::cmd_t  wr_cmd,
  input  logic            rd_en,
  output hrle_pkg::cmd_t  rd_cmd,
  output logic            q_empty,
  output logic            q_full
);

  hrle_pkg::cmd_t                 mem [hrle_pkg::FIFO_DEPTH];
  logic [hrle_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [hrle_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [hrle_pkg::FIFO_AW:0]     count;
  logic                           do_wr;
  logic                           do_rd;

  assign q_empty = (count == '0);
  assign q_full  = (count == (hrle_pkg::FIFO_AW + 1)'(hrle_pkg::FIFO_DEPTH));
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_cmd  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/hrle_front.sv @@
// Front end: accepts input items, tracks line fill and classifies each item.
module hrle_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic                   func,
  input  logic [7:0]             data_byte,
  input  logic [15:0]            address,
  input  logic                   end_of_section,
  input  logic [15:0]            load_offset,
  input  logic                   q_full,
  output logic                   q_push,
  output hrle_pkg::cmd_t         q_cmd,
  output logic                   line_open
);

  logic [hrle_pkg::CNT_W-1:0] cnt;
  logic [hrle_pkg::CNT_W-1:0] cnt_inc;
  logic [hrle_pkg::CNT_W-1:0] cnt_next;
  logic                       data_close;

  localparam logic [hrle_pkg::CNT_W-1:0] LineBytesC = hrle_pkg::CNT_W'(hrle_pkg::LINE_BYTES);

  assign full      = q_full;
  assign q_push    = push && !q_full;
  assign line_open = (cnt != '0);
  assign cnt_inc   = cnt + 1'b1;
  assign data_close = (cnt_inc >= LineBytesC) || end_of_section;

  always_comb begin
    q_cmd.is_end = func;
    q_cmd.data   = data_byte;
    q_cmd.addr   = address + load_offset;
    if (func) begin
      q_cmd.opens  = 1'b0;
      q_cmd.closes = line_open;
      q_cmd.npad   = line_open ? (LineBytesC - cnt) : '0;
      cnt_next     = '0;
    end else begin
      q_cmd.opens  = !line_open;
      q_cmd.closes = data_close;
      q_cmd.npad   = data_close ? (LineBytesC - cnt_inc) : '0;
      cnt_next     = data_close ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (q_push) begin
      cnt <= cnt_next;
    end
  end

endmodule

@@ design/hrle_back.sv @@
// Back end: walks each command through its characters and holds the output register.
module hrle_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  hrle_pkg::cmd_t         q_head,
  output logic                   q_pop,
  input  logic [7:0]             pad_byte,
  input  logic [7:0]             line_terminator,
  input  logic                   pop,
  output logic                   empty,
  output logic [7:0]             out_char,
  output logic                   last_char
);

  typedef enum logic [3:0] {
    PH_AH0, PH_AH1, PH_AL0, PH_AL1,
    PH_DSP, PH_D0, PH_D1,
    PH_PSP, PH_P0, PH_P1,
    PH_CSP, PH_C0, PH_C1, PH_CT,
    PH_DOT, PH_DT
  } phase_t;

  phase_t                      phase;
  phase_t                      phase_next;
  phase_t                      first_phase;
  hrle_pkg::cmd_t              cur;
  logic                        cur_valid;
  logic [hrle_pkg::CNT_W-1:0]  pad_left;
  logic [hrle_pkg::CNT_W-1:0]  pad_left_next;
  logic [7:0]                  csum;
  logic [7:0]                  csum_next;
  logic                        out_valid;
  logic [7:0]                  ch;
  logic                        lst;
  logic                        step_done;
  logic                        adv;
  logic                        load;

  assign empty = !out_valid;
  assign adv   = cur_valid && (!out_valid || pop);
  assign load  = !q_empty && (!cur_valid || (adv && step_done));
  assign q_pop = load;

  always_comb begin
    if (q_head.is_end) begin
      if (q_head.closes) begin
        first_phase = (q_head.npad != '0) ? PH_PSP : PH_CSP;
      end else begin
        first_phase = PH_DOT;
      end
    end else begin
      first_phase = q_head.opens ? PH_AH0 : PH_DSP;
    end
  end

  always_comb begin
    ch            = hrle_pkg::CH_SPACE;
    lst           = 1'b0;
    step_done     = 1'b0;
    phase_next    = phase;
    csum_next     = csum;
    pad_left_next = pad_left;
    case (phase)
      PH_AH0: begin
        ch         = hrle_pkg::hex_char(cur.addr[15:12]);
        csum_next  = cur.addr[15:8];
        phase_next = PH_AH1;
      end
      PH_AH1: begin
        ch         = hrle_pkg::hex_char(cur.addr[11:8]);
        phase_next = PH_AL0;
      end
      PH_AL0: begin
        ch         = hrle_pkg::hex_char(cur.addr[7:4]);
        csum_next  = csum + cur.addr[7:0];
        phase_next = PH_AL1;
      end
      PH_AL1: begin
        ch         = hrle_pkg::hex_char(cur.addr[3:0]);
        phase_next = PH_DSP;
      end
      PH_DSP: begin
        phase_next = PH_D0;
      end
      PH_D0: begin
        ch         = hrle_pkg::hex_char(cur.data[7:4]);
        csum_next  = csum + cur.data;
        phase_next = PH_D1;
      end
      PH_D1: begin
        ch = hrle_pkg::hex_char(cur.data[3:0]);
        if (cur.closes) begin
          phase_next = (pad_left != '0) ? PH_PSP : PH_CSP;
        end else begin
          step_done = 1'b1;
          lst       = 1'b1;
        end
      end
      PH_PSP: begin
        phase_next = PH_P0;
      end
      PH_P0: begin
        ch         = hrle_pkg::hex_char(pad_byte[7:4]);
        csum_next  = csum + pad_byte;
        phase_next = PH_P1;
      end
      PH_P1: begin
        ch            = hrle_pkg::hex_char(pad_byte[3:0]);
        pad_left_next = pad_left - 1'b1;
        phase_next    = (pad_left == hrle_pkg::CNT_W'(1)) ? PH_CSP : PH_PSP;
      end
      PH_CSP: begin
        phase_next = PH_C0;
      end
      PH_C0: begin
        ch         = hrle_pkg::hex_char(csum[7:4]);
        phase_next = PH_C1;
      end
      PH_C1: begin
        ch         = hrle_pkg::hex_char(csum[3:0]);
        phase_next = PH_CT;
      end
      PH_CT: begin
        ch = line_terminator;
        if (cur.is_end) begin
          phase_next = PH_DOT;
        end else begin
          step_done = 1'b1;
          lst       = 1'b1;
        end
      end
      PH_DOT: begin
        ch         = hrle_pkg::CH_DOT;
        phase_next = PH_DT;
      end
      PH_DT: begin
        ch        = line_terminator;
        step_done = 1'b1;
        lst       = 1'b1;
      end
      default: begin
        phase_next = PH_DSP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DSP;
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      csum      <= '0;
      pad_left  <= '0;
    end else begin
      if (adv) begin
        csum      <= csum_next;
        out_char  <= ch;
        last_char <= lst;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      // A new command replaces the one that just finished in the same cycle.
      if (load) begin
        cur       <= q_head;
        phase     <= first_phase;
        pad_left  <= q_head.npad;
        cur_valid <= 1'b1;
      end else if (adv) begin
        phase    <= phase_next;
        pad_left <= pad_left_next;
        if (step_done) begin
          cur_valid <= 1'b0;
        end
      end
    end
  end

endmodule

@@ design/hex_record_line_encoder_top.sv @@
// Top level of the hex record line encoder: configuration registers and wiring.
//
// The block turns a stream of bytes into ASCII hex load records, eight bytes
// to a line, each line led by a four-digit address and closed by a checksum
// and the line terminator character. Input items are written like a queue:
// an item transfers at a clock edge with push high and full low. Each result
// is one character; the oldest one sits on out_char and last_char while empty
// is low and transfers at an edge with pop high. last_char marks the final
// character that an input item causes.
// Configuration registers (load offset, pad byte, line terminator) are written
// through cfg_valid/cfg_ready, which is always ready; write them only while
// the block is idle.
// The back end emits exactly one character per cycle while commands wait, so
// the output port sets the rate: a byte in the middle of a line gives 3
// characters, a byte that opens a line 4 more, closing a line 4 more plus 3 per
// padded slot, and the end command 2 (plus the line close if a line is open).
// An item goes through the command queue and the command register to out_char.
// A four-entry command queue lets the input side run ahead of the output side;
// when pop stays low the output register holds and the queue fills, then full
// rises. Synchronous reset empties both sides, closes no line, and restores
// the register defaults (terminator 31).
module hex_record_line_encoder_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            func,
  input  logic [7:0]                      data_byte,
  input  logic [15:0]                     address,
  input  logic                            end_of_section,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      out_char,
  output logic                            last_char,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hrle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hrle_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [15:0]    load_offset;
  logic [7:0]     pad_byte;
  logic [7:0]     line_terminator;
  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  hrle_pkg::cmd_t q_wr_cmd;
  hrle_pkg::cmd_t q_head;
  logic           line_open;

  // The register file accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_offset     <= '0;
      pad_byte        <= '0;
      line_terminator <= hrle_pkg::TERM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hrle_pkg::REG_LOAD_OFFSET: load_offset     <= cfg_data[15:0];
        hrle_pkg::REG_PAD_BYTE:    pad_byte        <= cfg_data[7:0];
        hrle_pkg::REG_LINE_TERM:   line_terminator <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // The front end counts bytes in the open line and decides, per item, whether
  // it opens a line, closes it, and how many pad slots the close needs.
  hrle_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .func           (func),
    .data_byte      (data_byte),
    .address        (address),
    .end_of_section (end_of_section),
    .load_offset    (load_offset),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_wr_cmd),
    .line_open      (line_open)
  );

  hrle_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_cmd  (q_wr_cmd),
    .rd_en   (q_pop),
    .rd_cmd  (q_head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  // The back end owns the checksum and sequences the characters of a command.
  hrle_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .pad_byte        (pad_byte),
    .line_terminator (line_terminator),
    .pop             (pop),
    .empty           (empty),
    .out_char        (out_char),
    .last_char       (last_char)
  );

  // The back end only takes a command that is actually queued.
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("back end took a command from an empty queue");

  // An end command always leaves no line open.
  a_end_closes_line: assert property (@(posedge clk) disable iff (rst)
    (push && !full && func) |=> !line_open)
    else $error("line still open after end command");

  // Reset leaves no character waiting.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result pending after reset");

  // A waiting character holds still until it transfers.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(last_char)))
    else $error("waiting character changed before its transfer");

endmodule
